@@ sv/block_run_coalescer_assert.svh @@
// Assertion macros for the block run coalescer.
`ifndef BLOCK_RUN_COALESCER_ASSERT_SVH
`define BLOCK_RUN_COALESCER_ASSERT_SVH
`ifndef SYNTH
`define BRC_ASSERT_SAME(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) \
    else $error("block run coalescer check failed");
`define BRC_ASSERT_NEXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) \
    else $error("block run coalescer check failed");
`else
`define BRC_ASSERT_SAME(lbl, c, r, ante, cons)
`define BRC_ASSERT_NEXT(lbl, c, r, ante, cons)
`endif
`endif

@@ sv/brc_pkg.sv @@
// Shared types and constants of the block run coalescer.
`default_nettype none
package brc_pkg;
  localparam int BLK_W = 32;
  localparam int LEN_W = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [BLK_W-1:0] chunk_start;
    logic [LEN_W-1:0] chunk_length;
    logic             list_done;
  } ext_t;

  typedef struct packed {
    logic two;
    ext_t e0;
    ext_t e1;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic run_open;
    logic list_stopped;
  } front_stat_t;
endpackage
`default_nettype wire

@@ sv/brc_ifs.sv @@
// Request channel interfaces for block numbers in and extents out.
`default_nettype none
interface brc_blk_if;
  logic                      valid;
  logic                      ready;
  logic [brc_pkg::BLK_W-1:0] block_number;
  logic                      end_of_list;
  modport source(output valid, block_number, end_of_list, input ready);
  modport sink(input valid, block_number, end_of_list, output ready);
endinterface

interface brc_ext_if;
  logic                      valid;
  logic                      ready;
  logic [brc_pkg::BLK_W-1:0] chunk_start;
  logic [brc_pkg::LEN_W-1:0] chunk_length;
  logic                      list_done;
  logic                      last_of_item;
  modport source(output valid, chunk_start, chunk_length, list_done, last_of_item,
                 input ready);
  modport sink(input valid, chunk_start, chunk_length, list_done, last_of_item,
               output ready);
endinterface
`default_nettype wire

@@ sv/brc_queue.sv @@
// Short queue of extent records between the classifier and the emitter.
`default_nettype none
module brc_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire brc_pkg::rec_t    wdata,
  input  wire logic             pop,
  output brc_pkg::rec_t         rdata,
  output brc_pkg::q_stat_t      stat
);
  brc_pkg::rec_t                     entries [brc_pkg::QUEUE_DEPTH];
  logic [brc_pkg::QPTR_W-1:0]        wptr;
  logic [brc_pkg::QPTR_W-1:0]        rptr;
  logic [brc_pkg::QCNT_W-1:0]        count;
  logic                              do_push;
  logic                              do_pop;

  assign stat.full  = (count == brc_pkg::QCNT_W'(brc_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = entries[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/brc_front.sv @@
// Front end: accepts block numbers, tracks the open run and forms extent records.
`default_nettype none
module brc_front #(
  parameter int MAX_LIST = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst,
  brc_blk_if.sink                  blocks,
  input  wire brc_pkg::q_stat_t    q_stat,
  output logic                     push,
  output brc_pkg::rec_t            rec,
  output brc_pkg::front_stat_t     stat
);
  localparam int RL_W = $clog2(MAX_LIST + 1);

  logic                      run_open, run_open_next;
  logic                      list_stopped, list_stopped_next;
  logic [brc_pkg::BLK_W-1:0] run_first, run_first_next;
  logic [brc_pkg::BLK_W-1:0] run_last, run_last_next;
  logic [RL_W-1:0]           run_len, run_len_next;
  logic                      accept;
  logic                      mid_emit;
  logic                      mid_done;
  logic                      eol_emit;
  logic                      mid_open;
  logic [brc_pkg::BLK_W-1:0] mid_first;
  logic [brc_pkg::BLK_W-1:0] mid_last;
  logic [RL_W-1:0]           mid_len;
  logic                      mid_stopped;
  logic [31:0]               len_cur;
  logic [31:0]               len_mid;
  brc_pkg::ext_t             ext_mid;
  brc_pkg::ext_t             ext_eol;

  assign blocks.ready      = !q_stat.full;
  assign accept            = blocks.valid && blocks.ready;
  assign stat.run_open     = run_open;
  assign stat.list_stopped = list_stopped;

  always_comb begin
    mid_emit    = 1'b0;
    mid_done    = 1'b0;
    mid_open    = run_open;
    mid_first   = run_first;
    mid_last    = run_last;
    mid_len     = run_len;
    mid_stopped = list_stopped;
    if (!list_stopped) begin
      if (blocks.block_number == '0) begin
        mid_emit    = run_open;
        mid_done    = 1'b1;
        mid_open    = 1'b0;
        mid_first   = '0;
        mid_last    = '0;
        mid_len     = '0;
        mid_stopped = 1'b1;
      end else if (run_open && blocks.block_number == run_last + 1'b1 &&
                   run_len < RL_W'(MAX_LIST)) begin
        mid_last = blocks.block_number;
        mid_len  = run_len + 1'b1;
      end else begin
        mid_emit  = run_open;
        mid_open  = 1'b1;
        mid_first = blocks.block_number;
        mid_last  = blocks.block_number;
        mid_len   = RL_W'(1);
      end
    end
    eol_emit = blocks.end_of_list && mid_open;
  end

  assign len_cur = 32'(run_len);
  assign len_mid = 32'(mid_len);

  always_comb begin
    ext_mid.chunk_start  = run_first;
    ext_mid.chunk_length = len_cur[brc_pkg::LEN_W-1:0];
    ext_mid.list_done    = mid_done;
    ext_eol.chunk_start  = mid_first;
    ext_eol.chunk_length = len_mid[brc_pkg::LEN_W-1:0];
    ext_eol.list_done    = 1'b1;
    if (mid_emit) begin
      rec.two = eol_emit;
      rec.e0  = ext_mid;
      rec.e1  = ext_eol;
    end else begin
      rec.two = 1'b0;
      rec.e0  = ext_eol;
      rec.e1  = ext_eol;
    end
    push = accept && (mid_emit || eol_emit);
  end

  always_comb begin
    run_open_next     = run_open;
    run_first_next    = run_first;
    run_last_next     = run_last;
    run_len_next      = run_len;
    list_stopped_next = list_stopped;
    if (accept) begin
      if (blocks.end_of_list) begin
        run_open_next     = 1'b0;
        run_first_next    = '0;
        run_last_next     = '0;
        run_len_next      = '0;
        list_stopped_next = 1'b0;
      end else begin
        run_open_next     = mid_open;
        run_first_next    = mid_first;
        run_last_next     = mid_last;
        run_len_next      = mid_len;
        list_stopped_next = mid_stopped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open     <= 1'b0;
      list_stopped <= 1'b0;
      run_first    <= '0;
      run_last     <= '0;
      run_len      <= '0;
    end else begin
      run_open     <= run_open_next;
      list_stopped <= list_stopped_next;
      run_first    <= run_first_next;
      run_last     <= run_last_next;
      run_len      <= run_len_next;
    end
  end
endmodule
`default_nettype wire

@@ sv/brc_back.sv @@
// Back end: drains extent records and sends one or two extents per record.
`default_nettype none
module brc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire brc_pkg::rec_t     rec,
  input  wire brc_pkg::q_stat_t  q_stat,
  output logic                   pop,
  brc_ext_if.source              extents
);
  logic          sub;
  logic          sub_next;
  logic          fire;
  brc_pkg::ext_t cur;

  always_comb begin
    cur                  = sub ? rec.e1 : rec.e0;
    extents.valid        = !q_stat.empty;
    extents.chunk_start  = cur.chunk_start;
    extents.chunk_length = cur.chunk_length;
    extents.list_done    = cur.list_done;
    extents.last_of_item = !rec.two || sub;
    fire                 = extents.valid && extents.ready;
    pop                  = fire && extents.last_of_item;
    sub_next             = fire ? !extents.last_of_item : sub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else begin
      sub <= sub_next;
    end
  end
endmodule
`default_nettype wire

@@ sv/block_run_coalescer.sv @@
// Top level of the block run coalescer.
// The blocks channel takes one block number per request, with end_of_list
// marking the final entry of a list; a zero block ends the list early.
// The extents channel returns runs of consecutive blocks as chunk_start and
// chunk_length, with list_done on the last extent of a list and last_of_item
// on the final extent caused by one input request.
// A new block request is taken every cycle while the four-entry record queue
// has room. A request that closes an extent writes a record into the queue;
// the extent is sent from the queue head. Two extents from one request go out
// in turn; with a ready receiver the output port sustains one extent per cycle.
// When the receiver stalls, records collect in the queue and the blocks
// channel drops ready once the queue is full; nothing is lost.
// Reset clears the open run, the stopped flag and the queue; no extent is
// pending after reset.
// Runs are limited to MAX_LIST blocks; a longer run is split.
`default_nettype none
`include "block_run_coalescer_assert.svh"
module block_run_coalescer #(
  parameter int MAX_LIST = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst,
  brc_blk_if.sink    blocks,
  brc_ext_if.source  extents
);
  logic                 push;
  logic                 pop;
  brc_pkg::rec_t        wrec;
  brc_pkg::rec_t        rrec;
  brc_pkg::q_stat_t     q_stat;
  brc_pkg::front_stat_t f_stat;

  brc_front #(
    .MAX_LIST(MAX_LIST)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .blocks (blocks),
    .q_stat (q_stat),
    .push   (push),
    .rec    (wrec),
    .stat   (f_stat)
  );

  brc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wrec),
    .pop   (pop),
    .rdata (rrec),
    .stat  (q_stat)
  );

  brc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .rec     (rrec),
    .q_stat  (q_stat),
    .pop     (pop),
    .extents (extents)
  );

  `BRC_ASSERT_SAME(a_no_push_full, clk, rst, push, !q_stat.full)
  `BRC_ASSERT_NEXT(a_eol_clears, clk, rst, blocks.valid && blocks.ready && blocks.end_of_list, !f_stat.run_open && !f_stat.list_stopped)
  `BRC_ASSERT_SAME(a_len_range, clk, rst, extents.valid && (MAX_LIST < 2048), (extents.chunk_length != '0) && (32'(extents.chunk_length) <= 32'(MAX_LIST)))
endmodule
`default_nettype wire
